[hw/rtl/hlrf_pkg.sv]
// Shared constants and types for the HL-RF search direction core.
// Used by hlrf_divider and hlrf_search_direction_core; depends on nothing.
`default_nettype none

package hlrf_pkg;

   // Vector storage depth and the widths that follow from it.
   localparam int MAX_DIM = 32;
   localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CNT_W   = $clog2(MAX_DIM + 1);

   // Datapath widths.
   localparam int DATA_W  = 32;               // Q16.16 element
   localparam int ACC_W   = 64;               // Q32.32 accumulators
   localparam int MUL_W   = DATA_W + 1;       // signed multiplier operand
   localparam int PROD_W  = 2 * MUL_W;        // multiplier product
   localparam int QUO_W   = DATA_W + ACC_W;   // wide dividend and quotient
   localparam int QCNT_W  = $clog2(QUO_W + 1);
   localparam int DIFF_W  = 36;               // final direction before clamping

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOT,
      ST_SQ,
      ST_ACC,
      ST_CHECK,
      ST_ERR,
      ST_NUMER,
      ST_READ,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_RESULT
   } state_type;

endpackage

`default_nettype wire

[hw/rtl/hlrf_search_direction_core.sv]
// HL-RF search direction core: loads point and gradient elements and emits
// d_i = -grad_i*(g - grad.u)/|grad|^2 - u_i in saturated Q16.16.
// Uses hlrf_pkg and instantiates hlrf_divider.
//
// Usage:
//   The req_ channel carries one u element, one gradient element, g and a
//   last flag per beat. Each beat is stored and folded into the dot product
//   and squared norm through one shared 33x33 multiplier; a new beat is taken
//   only after the last passed ST_DOT, ST_SQ and ST_ACC. Beats past MAX_DIM
//   are dropped, but a last flag on them still starts the emit phase.
//   After the last beat the rsp_ channel delivers one beat per stored
//   element in order, or a single error beat when the gradient norm is
//   zero. Each direction element needs two partial products and a 96-step
//   restoring division. req_stall stays high from an accepted beat until
//   the core is ready for the next one, and through the whole emit phase.
//   Results sit in an output register; while rsp_stall holds it, the core
//   finishes the next element and then waits. After the final result is
//   loaded the core takes new beats even if that result is still stalled.
//   Synchronous reset clears the sequencer, accumulators and element count;
//   the element memory is not cleared.
`default_nettype none

module hlrf_search_direction_core (
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic signed [31:0]  req_u_element,
   input  wire logic signed [31:0]  req_grad_element,
   input  wire logic signed [31:0]  req_g_value,
   input  wire logic                req_last_element,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic signed [31:0]       rsp_direction_element,
   output logic                     rsp_zero_norm_error,
   output logic                     rsp_last_result,
   output logic                     rsp_saturated
);

   localparam int DW = hlrf_pkg::DATA_W;
   localparam int AW = hlrf_pkg::ACC_W;
   localparam int QW = hlrf_pkg::QUO_W;
   localparam int FW = hlrf_pkg::DIFF_W;

   hlrf_pkg::state_type state_ff, state_in;

   // Input beat registers.
   logic signed [DW-1:0]  u_ff, gr_ff, g_ff;
   logic                  last_ff;

   // Accumulators and counters.
   logic signed [AW-1:0]  dot_ff, dot_in;
   logic [AW-1:0]         norm_ff, norm_in;
   logic [hlrf_pkg::CNT_W-1:0] count_ff, count_in;
   logic [hlrf_pkg::CNT_W-1:0] idx_ff, idx_in;

   // Numerator as sign and magnitude.
   logic                  num_neg_ff;
   logic [AW-1:0]         num_mag_ff;
   logic signed [AW:0]    num_diff;

   // Shared multiplier.
   logic signed [hlrf_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic signed [hlrf_pkg::PROD_W-1:0] prod_ff;
   logic [AW-1:0]                      lo_ff;
   logic                               mul_en;

   // Element memory.
   logic [2*DW-1:0]       mem [hlrf_pkg::MAX_DIM];
   logic [2*DW-1:0]       rd_data_ff;
   logic signed [DW-1:0]  rd_u, rd_gr;
   logic [DW-1:0]         rd_gr_mag;
   logic                  mem_we;

   // Divider connection.
   logic                  div_start, div_done;
   logic [QW-1:0]         div_num, quo;

   // Result formation.
   logic                  q_neg, q_far, last_elem;
   logic signed [FW-1:0]  q_s, d_full;
   logic                  d_hi, d_lo;
   logic signed [DW-1:0]  d_val;
   logic                  d_sat;

   // Control strobes.
   logic                  req_accept, room, out_free, rsp_load, load_err, acc_clear;
   logic                  rsp_valid_ff;

   assign req_accept = req_valid && !req_stall;
   assign room       = (count_ff < hlrf_pkg::CNT_W'(hlrf_pkg::MAX_DIM));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign last_elem  = ((idx_ff + 1'b1) == count_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hlrf_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (room) begin
                  state_in = hlrf_pkg::ST_DOT;
               end else if (req_last_element) begin
                  state_in = hlrf_pkg::ST_CHECK;
               end
            end
         end
         hlrf_pkg::ST_DOT:   state_in = hlrf_pkg::ST_SQ;
         hlrf_pkg::ST_SQ:    state_in = hlrf_pkg::ST_ACC;
         hlrf_pkg::ST_ACC:   state_in = last_ff ? hlrf_pkg::ST_CHECK : hlrf_pkg::ST_IDLE;
         hlrf_pkg::ST_CHECK: begin
            state_in = (norm_ff == '0) ? hlrf_pkg::ST_ERR : hlrf_pkg::ST_NUMER;
         end
         hlrf_pkg::ST_ERR: begin
            if (out_free) begin
               state_in = hlrf_pkg::ST_IDLE;
            end
         end
         hlrf_pkg::ST_NUMER:     state_in = hlrf_pkg::ST_READ;
         hlrf_pkg::ST_READ:      state_in = hlrf_pkg::ST_MUL_LO;
         hlrf_pkg::ST_MUL_LO:    state_in = hlrf_pkg::ST_MUL_HI;
         hlrf_pkg::ST_MUL_HI:    state_in = hlrf_pkg::ST_DIV_START;
         hlrf_pkg::ST_DIV_START: state_in = hlrf_pkg::ST_DIV_WAIT;
         hlrf_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = hlrf_pkg::ST_RESULT;
            end
         end
         hlrf_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = last_elem ? hlrf_pkg::ST_IDLE : hlrf_pkg::ST_READ;
            end
         end
         default: state_in = hlrf_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: handshake, multiplier operands and strobes.
   always_comb begin
      req_stall = 1'b1;
      mul_en    = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      mem_we    = 1'b0;
      div_start = 1'b0;
      rsp_load  = 1'b0;
      load_err  = 1'b0;
      acc_clear = 1'b0;
      unique case (state_ff)
         hlrf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            mem_we    = req_valid && room;
         end
         hlrf_pkg::ST_DOT: begin
            mul_en = 1'b1;
            mul_a  = hlrf_pkg::MUL_W'(gr_ff);
            mul_b  = hlrf_pkg::MUL_W'(u_ff);
         end
         hlrf_pkg::ST_SQ: begin
            mul_en = 1'b1;
            mul_a  = hlrf_pkg::MUL_W'(gr_ff);
            mul_b  = hlrf_pkg::MUL_W'(gr_ff);
         end
         hlrf_pkg::ST_ERR: begin
            rsp_load  = out_free;
            load_err  = 1'b1;
            acc_clear = out_free;
         end
         hlrf_pkg::ST_MUL_LO: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, rd_gr_mag};
            mul_b  = {1'b0, num_mag_ff[DW-1:0]};
         end
         hlrf_pkg::ST_MUL_HI: begin
            mul_en = 1'b1;
            mul_a  = {1'b0, rd_gr_mag};
            mul_b  = {1'b0, num_mag_ff[AW-1:DW]};
         end
         hlrf_pkg::ST_DIV_START: begin
            div_start = 1'b1;
         end
         hlrf_pkg::ST_RESULT: begin
            rsp_load  = out_free;
            acc_clear = out_free && last_elem;
         end
         default: begin
         end
      endcase
   end

   // Saturating accumulation and run bookkeeping.
   always_comb begin
      logic signed [AW-1:0] dsum;
      logic [AW:0]          nsum;
      dsum     = dot_ff + prod_ff[AW-1:0];
      nsum     = {1'b0, norm_ff} + {1'b0, prod_ff[AW-1:0]};
      dot_in   = dot_ff;
      norm_in  = norm_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      if (state_ff == hlrf_pkg::ST_SQ) begin
         if ((dot_ff[AW-1] == prod_ff[AW-1]) && (dsum[AW-1] != dot_ff[AW-1])) begin
            dot_in = dot_ff[AW-1] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
         end else begin
            dot_in = dsum;
         end
      end
      if (state_ff == hlrf_pkg::ST_ACC) begin
         norm_in  = nsum[AW] ? '1 : nsum[AW-1:0];
         count_in = count_ff + 1'b1;
      end
      if (state_ff == hlrf_pkg::ST_NUMER) begin
         idx_in = '0;
      end
      if ((state_ff == hlrf_pkg::ST_RESULT) && out_free) begin
         idx_in = idx_ff + 1'b1;
      end
      if (acc_clear) begin
         dot_in   = '0;
         norm_in  = '0;
         count_in = '0;
      end
   end

   // Numerator g - grad.u in Q32.32, exact in one extra bit.
   assign num_diff = {{(AW + 1 - DW - 16){g_ff[DW-1]}}, g_ff, 16'b0} - {dot_ff[AW-1], dot_ff};

   // Stored element read back for the emit phase.
   assign rd_u      = rd_data_ff[2*DW-1:DW];
   assign rd_gr     = rd_data_ff[DW-1:0];
   assign rd_gr_mag = rd_gr[DW-1] ? DW'(-rd_gr) : DW'(rd_gr);

   // Full product |grad_i| * |num| from its two partial products.
   assign div_num = {{(QW - AW){1'b0}}, lo_ff} + {prod_ff[AW-1:0], {(QW - AW){1'b0}}};

   hlrf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .numerator (div_num),
      .divisor   (norm_ff),
      .done      (div_done),
      .quotient  (quo)
   );

   // Direction from the quotient: negate, subtract u_i and clamp to Q16.16.
   always_comb begin
      q_neg  = num_neg_ff ^ rd_gr[DW-1];
      q_far  = (quo[QW-1:34] != '0) || (quo[33] && (quo[32:0] != '0));
      q_s    = q_neg ? -$signed({2'b00, quo[33:0]}) : $signed({2'b00, quo[33:0]});
      d_full = -q_s - FW'(rd_u);
      d_hi   = !d_full[FW-1] && (d_full[FW-2:DW-1] != '0);
      d_lo   = d_full[FW-1] && (d_full[FW-2:DW-1] != '1);
      if (q_far) begin
         d_val = q_neg ? {1'b0, {(DW-1){1'b1}}} : {1'b1, {(DW-1){1'b0}}};
         d_sat = 1'b1;
      end else if (d_hi) begin
         d_val = {1'b0, {(DW-1){1'b1}}};
         d_sat = 1'b1;
      end else if (d_lo) begin
         d_val = {1'b1, {(DW-1){1'b0}}};
         d_sat = 1'b1;
      end else begin
         d_val = d_full[DW-1:0];
         d_sat = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hlrf_pkg::ST_IDLE;
         dot_ff       <= '0;
         norm_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dot_ff   <= dot_in;
         norm_ff  <= norm_in;
         count_ff <= count_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (req_accept) begin
         u_ff    <= req_u_element;
         gr_ff   <= req_grad_element;
         g_ff    <= req_g_value;
         last_ff <= req_last_element;
      end
      if (mul_en) begin
         prod_ff <= mul_a * mul_b;
      end
      if (state_ff == hlrf_pkg::ST_MUL_HI) begin
         lo_ff <= prod_ff[AW-1:0];
      end
      if (state_ff == hlrf_pkg::ST_NUMER) begin
         num_neg_ff <= num_diff[AW];
         num_mag_ff <= num_diff[AW] ? AW'(-num_diff) : num_diff[AW-1:0];
      end
      if (rsp_load) begin
         rsp_direction_element <= load_err ? '0 : d_val;
         rsp_zero_norm_error   <= load_err;
         rsp_last_result       <= load_err || last_elem;
         rsp_saturated         <= load_err ? 1'b0 : d_sat;
      end
   end

   // Element memory: one write port while loading, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[hlrf_pkg::IDX_W-1:0]] <= {req_u_element, req_grad_element};
      end
      rd_data_ff <= mem[idx_ff[hlrf_pkg::IDX_W-1:0]];
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   // An error beat carries a zero, unclipped direction and closes the run.
   a_err_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_zero_norm_error) |->
         (rsp_last_result && (rsp_direction_element == '0) && !rsp_saturated))
      else $error("error beat has bad fields");

   // The divider only finishes while the sequencer waits for it.
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == hlrf_pkg::ST_DIV_WAIT))
      else $error("divider finished outside its wait state");

   // The element count never passes the memory depth.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= hlrf_pkg::CNT_W'(hlrf_pkg::MAX_DIM))
      else $error("element count beyond depth");

   // A new result never overwrites one that is still stalled.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result register overwritten while stalled");
`endif

endmodule

`default_nettype wire

[hw/rtl/hlrf_divider.sv]
// Restoring unsigned divider, one quotient bit per clock.
// Divides a QUO_W-bit dividend by an ACC_W-bit divisor; uses hlrf_pkg.
`default_nettype none

module hlrf_divider (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [hlrf_pkg::QUO_W-1:0]   numerator,
   input  wire logic [hlrf_pkg::ACC_W-1:0]   divisor,
   output logic                              done,
   output logic [hlrf_pkg::QUO_W-1:0]        quotient
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [hlrf_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic [hlrf_pkg::QUO_W-1:0]    num_ff, num_in;
   logic [hlrf_pkg::ACC_W-1:0]    den_ff, den_in;
   logic [hlrf_pkg::ACC_W-1:0]    rem_ff, rem_in;
   logic [hlrf_pkg::ACC_W:0]      shifted;
   logic                          fits;

   // One step: shift the next dividend bit into the remainder and subtract if it fits.
   // The quotient bits fill the dividend register from the bottom as it empties.
   always_comb begin
      shifted = {rem_ff, num_ff[hlrf_pkg::QUO_W-1]};
      fits    = (shifted >= {1'b0, den_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = hlrf_pkg::QCNT_W'(hlrf_pkg::QUO_W);
         num_in  = numerator;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? hlrf_pkg::ACC_W'(shifted - {1'b0, den_ff})
                       : shifted[hlrf_pkg::ACC_W-1:0];
         num_in = {num_ff[hlrf_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == hlrf_pkg::QCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state is reset; the datapath registers are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = num_ff;

endmodule

`default_nettype wire

[tb/sv/hlrf_search_direction_core_tb.sv]
// Self-checking testbench for hlrf_search_direction_core: drives vectors of point and
// gradient elements and checks each search direction beat against an in-bench predictor.
// Depends on hlrf_pkg and the hlrf_search_direction_core RTL.
`timescale 1ns / 100ps

module hlrf_search_direction_core_tb;

   localparam int STALL_LIMIT = 3000;
   localparam int RANDOM_BEATS = 90;
   localparam int TAIL_CYCLES = 300;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
   localparam logic signed [67:0] WIDE_MAX = 68'sd2147483647;
   localparam logic signed [67:0] WIDE_MIN = -68'sd2147483648;

   // Kinds of element content for generated vectors.
   typedef enum int {FILL_SMALL, FILL_FULL, FILL_EXTREME, FILL_ZERO_GRAD} fill_kind_type;

   typedef struct packed {
      logic signed [31:0] direction;
      logic               zero_norm;
      logic               last;
      logic               sat;
   } direction_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_u_element = '0;
   logic signed [31:0] req_grad_element = '0;
   logic signed [31:0] req_g_value = '0;
   logic               req_last_element = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_direction_element;
   logic               rsp_zero_norm_error;
   logic               rsp_last_result;
   logic               rsp_saturated;

   // Predictor state: stored vector, accumulators and element count.
   logic signed [31:0] point_mem [hlrf_pkg::MAX_DIM];
   logic signed [31:0] grad_mem [hlrf_pkg::MAX_DIM];
   logic signed [63:0] dot_acc = '0;
   logic [63:0]        norm_acc = '0;
   int                 loaded_count = 0;

   direction_result_type expected_directions [$];

   bit steady_flow = 1'b0;
   int error_count = 0;
   int beats_sent = 0;
   int vectors_sent = 0;
   int results_checked = 0;
   int saturated_seen = 0;
   int zero_norm_seen = 0;
   int stalled_cycles = 0;

   hlrf_search_direction_core u_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_u_element         (req_u_element),
      .req_grad_element      (req_grad_element),
      .req_g_value           (req_g_value),
      .req_last_element      (req_last_element),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_direction_element (rsp_direction_element),
      .rsp_zero_norm_error   (rsp_zero_norm_error),
      .rsp_last_result       (rsp_last_result),
      .rsp_saturated         (rsp_saturated)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] magnitude(input logic signed [63:0] v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Fold one accepted beat into the predictor; on the last beat, queue the directions.
   task automatic predict_direction(input logic signed [31:0] u, input logic signed [31:0] gr,
                                    input logic signed [31:0] g, input logic last);
      logic signed [63:0] prod;
      logic [63:0]        sq;
      logic [64:0]        dot_sum;
      logic [64:0]        norm_sum;
      logic signed [65:0] numer;
      logic [63:0]        numer_mag;
      logic               numer_neg;
      logic [127:0]       wide_prod;
      logic [127:0]       wide_quo;
      logic signed [67:0] diff;
      logic               q_neg;
      direction_result_type res;
      int                 n;
      if (loaded_count < hlrf_pkg::MAX_DIM) begin
         point_mem[loaded_count] = u;
         grad_mem[loaded_count] = gr;
         prod = 64'(gr) * 64'(u);
         sq = magnitude(gr) * magnitude(gr);
         // Dot product saturates at the signed 64-bit limits.
         dot_sum = {dot_acc[63], dot_acc} + {prod[63], prod};
         if (dot_sum[64] != dot_sum[63]) begin
            dot_acc = dot_sum[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
         end else begin
            dot_acc = dot_sum[63:0];
         end
         // Squared norm saturates at all ones.
         norm_sum = {1'b0, norm_acc} + {1'b0, sq};
         norm_acc = norm_sum[64] ? '1 : norm_sum[63:0];
         loaded_count++;
      end
      if (!last) return;

      n = loaded_count;
      if (norm_acc == 0) begin
         res = '{direction: '0, zero_norm: 1'b1, last: 1'b1, sat: 1'b0};
         expected_directions.push_back(res);
      end else begin
         // Numerator g - grad.u, exact in Q32.32.
         numer = 66'(g) * 66'sd65536 - 66'(dot_acc);
         numer_neg = numer < 0;
         numer_mag = numer_neg ? 64'(-numer) : 64'(numer);
         for (int i = 0; i < n; i++) begin
            wide_prod = {64'b0, magnitude(grad_mem[i])} * {64'b0, numer_mag};
            wide_quo = wide_prod / {64'b0, norm_acc};
            q_neg = numer_neg != grad_mem[i][31];
            res.zero_norm = 1'b0;
            res.last = (i == n - 1);
            if (wide_quo[127:64] != 0 || wide_quo[63:0] > 64'h2_0000_0000) begin
               res.direction = q_neg ? Q_MAX : Q_MIN;
               res.sat = 1'b1;
            end else begin
               diff = (q_neg ? $signed({4'b0, wide_quo[63:0]})
                             : -$signed({4'b0, wide_quo[63:0]})) - 68'(point_mem[i]);
               if (diff > WIDE_MAX) begin
                  res.direction = Q_MAX;
                  res.sat = 1'b1;
               end else if (diff < WIDE_MIN) begin
                  res.direction = Q_MIN;
                  res.sat = 1'b1;
               end else begin
                  res.direction = diff[31:0];
                  res.sat = 1'b0;
               end
            end
            expected_directions.push_back(res);
         end
      end
      dot_acc = '0;
      norm_acc = '0;
      loaded_count = 0;
      vectors_sent++;
   endtask

   // Send one request beat after a random gap (none in steady stretches) and wait for it to be taken.
   task automatic send_beat(input logic signed [31:0] u, input logic signed [31:0] gr,
                            input logic signed [31:0] g, input logic last);
      int unsigned gap;
      gap = steady_flow ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_u_element <= u;
      req_grad_element <= gr;
      req_g_value <= g;
      req_last_element <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
      predict_direction(u, gr, g, last);
   endtask

   function automatic logic signed [31:0] pick_value(input fill_kind_type kind);
      case (kind)
         FILL_SMALL: return 32'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         FILL_EXTREME: begin
            case ($urandom_range(0, 4))
               0: return Q_MIN;
               1: return Q_MAX;
               2: return '0;
               3: return -32'sd1;
               default: return 32'sd1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Send a whole vector of generated elements, last flag on the final beat.
   task automatic send_vector(input int len, input fill_kind_type kind);
      logic signed [31:0] gr;
      fill_kind_type      u_kind;
      fill_kind_type      g_kind;
      u_kind = kind;
      if (kind == FILL_ZERO_GRAD) u_kind = FILL_FULL;
      g_kind = FILL_FULL;
      if (kind == FILL_EXTREME) g_kind = FILL_EXTREME;
      for (int k = 0; k < len; k++) begin
         gr = (kind == FILL_ZERO_GRAD) ? '0 : pick_value(kind);
         send_beat(pick_value(u_kind), gr, pick_value(g_kind), k == len - 1);
      end
   endtask

   task automatic test_single_elements();
      send_beat(Q_ONE, Q_ONE, 32'sh0000_8000, 1'b1);
      send_beat(-32'sh0002_8000, 32'sh0000_C000, -32'sh0003_0000, 1'b1);
   endtask

   task automatic test_zero_gradient();
      send_beat(32'sh1234_5678, '0, Q_ONE, 1'b1);
      send_beat(Q_MIN, '0, Q_MAX, 1'b0);
      send_beat(Q_MAX, '0, Q_MIN, 1'b1);
   endtask

   task automatic test_field_extremes();
      send_beat(Q_MIN, Q_MAX, '0, 1'b0);
      send_beat(Q_MAX, Q_MIN, '0, 1'b0);
      send_beat(-32'sd1, 32'sd1, Q_MAX, 1'b1);
      send_beat('0, -32'sd1, Q_MIN, 1'b1);
      send_beat(Q_MAX, Q_MAX, Q_MIN, 1'b1);
   endtask

   // Four maximal products per vector overflow both accumulators; the dot product goes once upward and once downward.
   task automatic test_accumulator_saturation();
      for (int k = 0; k < 4; k++) send_beat(Q_MIN, Q_MIN, Q_MAX, k == 3);
      for (int k = 0; k < 4; k++) send_beat(Q_MAX, Q_MIN, Q_MIN, k == 3);
   endtask

   // Beats past the storage depth are dropped, the last flag still starts the emit phase.
   task automatic test_overlong_vector();
      send_vector(hlrf_pkg::MAX_DIM + 2, FILL_SMALL);
   endtask

   task automatic test_random_vectors();
      int          start_beats;
      int          len;
      int unsigned pick;
      fill_kind_type kind;
      start_beats = beats_sent;
      while (beats_sent - start_beats < RANDOM_BEATS) begin
         steady_flow = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 19);
         if (pick < 13) len = $urandom_range(1, 6);
         else if (pick < 19) len = $urandom_range(7, hlrf_pkg::MAX_DIM);
         else len = $urandom_range(hlrf_pkg::MAX_DIM + 1, hlrf_pkg::MAX_DIM + 3);
         pick = $urandom_range(0, 19);
         if (pick < 14) kind = FILL_SMALL;
         else if (pick < 17) kind = FILL_FULL;
         else if (pick < 19) kind = FILL_EXTREME;
         else kind = FILL_ZERO_GRAD;
         send_vector(len, kind);
      end
      steady_flow = 1'b0;
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      error_count++;
      $display("[%0t] mismatch at result %0d, %s: expected %h, got %h",
               $realtime, results_checked, what, want, got);
   endtask

   // Result side: random stall before each beat, or none in steady stretches.
   initial begin : result_backpressure
      int unsigned hold;
      forever begin
         hold = steady_flow ? 0 : $urandom_range(0, 5);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Compare every accepted result beat with the oldest expected direction.
   always @(posedge clock) begin : result_check
      direction_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_directions.size() == 0) begin
            report_mismatch("unexpected result beat", '0, rsp_direction_element);
         end else begin
            want = expected_directions.pop_front();
            if (rsp_direction_element !== want.direction)
               report_mismatch("direction_element", want.direction, rsp_direction_element);
            if (rsp_zero_norm_error !== want.zero_norm)
               report_mismatch("zero_norm_error", want.zero_norm, rsp_zero_norm_error);
            if (rsp_last_result !== want.last)
               report_mismatch("last_result", want.last, rsp_last_result);
            if (rsp_saturated !== want.sat)
               report_mismatch("saturated", want.sat, rsp_saturated);
            if (want.sat) saturated_seen++;
            if (want.zero_norm) zero_norm_seen++;
         end
         results_checked++;
      end
   end

   // Watchdog: ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("Timeout: no beat accepted for %0d cycles, %0d results outstanding",
                  stalled_cycles, expected_directions.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      test_single_elements();
      test_zero_gradient();
      test_field_extremes();
      test_accumulator_saturation();
      test_overlong_vector();
      test_random_vectors();
      req_valid <= 1'b0;

      // Drain outstanding results, then watch for stray beats.
      while (expected_directions.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d vectors in %0d beats; %0d result beats checked.",
               vectors_sent, beats_sent, results_checked);
      $display("Of those, %0d were saturated and %0d reported a zero gradient norm; %0d mismatches.",
               saturated_seen, zero_norm_seen, error_count);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
